### sv/wbms_pkg.sv
// Shared types and constants for the weighted bipartition match sum block.
package wbms_pkg;

   localparam int SIDE_W      = 64;
   localparam int WEIGHT_IN_W = 16;
   localparam int SCORE_W     = 26;
   localparam int SUM_W       = 33;

   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_QUERY = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]             kind;
      logic [SIDE_W-1:0]      first_side;
      logic [SIDE_W-1:0]      second_side;
      logic [WEIGHT_IN_W-1:0] entry_weight;
   } req_type;

   typedef struct packed {
      logic [SCORE_W-1:0] total_score;
      logic               table_overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic entry_load;
      logic table_clear;
      logic query_start;
      logic read_issue;
      logic rsp_capture;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic scan_last;
      logic pipe_busy;
   } sts_type;

endpackage

### sv/weighted_bipartition_match_sum.sv
// Top level of the weighted bipartition match sum block.
//
//   port group   dir   carries
//   req_*        in    one beat: load entry, query tripartition or clear table
//   rsp_*        out   one beat per query: summed weight and overflow flag
//
// Load and clear are done as their beat is taken. A query makes one table read
// per stored entry through a single registered memory read port (none on an
// empty table), then drains the read and accumulate stages.
// Reset clears the entry count and the overflow flag; table contents are kept.
// A finished result waits in its output register; a new beat is taken while it
// waits, and only the capture of the next query result stalls on rsp_ready.
module weighted_bipartition_match_sum #(
   parameter int TAXA        = 64,
   parameter int ENTRIES     = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wbms_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wbms_pkg::rsp_type   rsp_data
);

   wbms_pkg::cmd_type cmd;
   wbms_pkg::sts_type sts;

   wbms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   wbms_datapath #(
      .TAXA        (TAXA),
      .ENTRIES     (ENTRIES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

### sv/wbms_ctrl.sv
// Controller state machine: sequences loads, clears, table scans and result hand-off.
module wbms_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_kind,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  wbms_pkg::sts_type   sts,
   output wbms_pkg::cmd_type   cmd
);

   wbms_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic req_accept;
   logic slot_free;

   assign req_accept = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wbms_pkg::ST_IDLE: begin
            if (req_accept && req_kind == wbms_pkg::KIND_QUERY) begin
               state_in = sts.count_zero ? wbms_pkg::ST_DRAIN : wbms_pkg::ST_SCAN;
            end
         end
         wbms_pkg::ST_SCAN: begin
            if (sts.scan_last) begin
               state_in = wbms_pkg::ST_DRAIN;
            end
         end
         wbms_pkg::ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = slot_free ? wbms_pkg::ST_IDLE : wbms_pkg::ST_HOLD;
            end
         end
         wbms_pkg::ST_HOLD: begin
            if (slot_free) begin
               state_in = wbms_pkg::ST_IDLE;
            end
         end
         default: state_in = wbms_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         wbms_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.entry_load  = req_valid && req_kind == wbms_pkg::KIND_LOAD;
            cmd.table_clear = req_valid && req_kind == wbms_pkg::KIND_CLEAR;
            cmd.query_start = req_valid && req_kind == wbms_pkg::KIND_QUERY;
         end
         wbms_pkg::ST_SCAN: begin
            cmd.read_issue = 1'b1;
         end
         wbms_pkg::ST_DRAIN: begin
            cmd.rsp_capture = !sts.pipe_busy && slot_free;
         end
         wbms_pkg::ST_HOLD: begin
            cmd.rsp_capture = slot_free;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wbms_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_query_blocks_input: assert property (@(posedge clock) disable iff (reset)
      cmd.query_start |=> !req_ready)
      else $error("input taken while a query scan runs");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_capture |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result overwritten");

   a_valid_from_capture: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.rsp_capture))
      else $error("result valid without a capture");

   a_no_read_outside_scan: assert property (@(posedge clock) disable iff (reset)
      (cmd.read_issue || sts.pipe_busy) |-> !req_ready)
      else $error("table read overlaps input acceptance");

endmodule

### sv/wbms_datapath.sv
// Datapath: entry table memories, entry count, scan pipeline and score accumulator.
module wbms_datapath #(
   parameter int TAXA        = 64,
   parameter int ENTRIES     = 1024,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  wbms_pkg::req_type   req_data,
   input  wbms_pkg::cmd_type   cmd,
   output wbms_pkg::sts_type   sts,
   output wbms_pkg::rsp_type   rsp_data
);

   localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   function automatic logic side_fits(input logic [TAXA-1:0] x, input logic [TAXA-1:0] y,
                                      input logic [TAXA-1:0] u, input logic [TAXA-1:0] v);
      return ((u & ~x) == '0) && ((x & v) == '0) && ((y & v) != '0);
   endfunction

   logic [TAXA-1:0]        mem_a [ENTRIES];
   logic [TAXA-1:0]        mem_b [ENTRIES];
   logic [WEIGHT_BITS-1:0] mem_w [ENTRIES];

   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   overflow_ff, overflow_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;
   logic [TAXA-1:0]        q1_ff, q2_ff;
   logic [TAXA-1:0]        rd_a_ff, rd_b_ff;
   logic [WEIGHT_BITS-1:0] rd_w_ff;
   logic                   rd_vld_ff;
   logic [wbms_pkg::SCORE_W-1:0] acc_ff, acc_in;
   wbms_pkg::rsp_type      rsp_ff;

   logic                   table_full;
   logic                   wr_en;
   logic [31:0]            weight_ext;
   logic                   hit;
   logic [wbms_pkg::SUM_W-1:0] sum_wide;

   assign table_full = count_ff >= CNT_W'(ENTRIES);
   assign wr_en      = cmd.entry_load && !table_full;
   assign weight_ext = {16'b0, req_data.entry_weight};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[count_ff[ADDR_W-1:0]] <= req_data.first_side[TAXA-1:0];
         mem_b[count_ff[ADDR_W-1:0]] <= req_data.second_side[TAXA-1:0];
         mem_w[count_ff[ADDR_W-1:0]] <= weight_ext[WEIGHT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_issue) begin
         rd_a_ff <= mem_a[idx_ff];
         rd_b_ff <= mem_b[idx_ff];
         rd_w_ff <= mem_w[idx_ff];
      end
   end

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cmd.table_clear) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.entry_load) begin
         overflow_in = 1'b1;
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.query_start) begin
         idx_in = '0;
      end else if (cmd.read_issue) begin
         idx_in = idx_ff + ADDR_W'(1);
      end
   end

   assign hit = side_fits(q1_ff, q2_ff, rd_a_ff, rd_b_ff) ||
                side_fits(q2_ff, q1_ff, rd_a_ff, rd_b_ff) ||
                side_fits(q1_ff, q2_ff, rd_b_ff, rd_a_ff) ||
                side_fits(q2_ff, q1_ff, rd_b_ff, rd_a_ff);

   assign sum_wide = wbms_pkg::SUM_W'(acc_ff) + wbms_pkg::SUM_W'(rd_w_ff);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.query_start) begin
         acc_in = '0;
      end else if (rd_vld_ff && hit) begin
         if (sum_wide > wbms_pkg::SUM_W'(wbms_pkg::SCORE_MAX)) begin
            acc_in = wbms_pkg::SCORE_MAX;
         end else begin
            acc_in = sum_wide[wbms_pkg::SCORE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         rd_vld_ff   <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         rd_vld_ff   <= cmd.read_issue;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      acc_ff <= acc_in;
      if (cmd.query_start) begin
         q1_ff <= req_data.first_side[TAXA-1:0];
         q2_ff <= req_data.second_side[TAXA-1:0];
      end
      if (cmd.rsp_capture) begin
         rsp_ff.total_score    <= acc_ff;
         rsp_ff.table_overflow <= overflow_ff;
      end
   end

   assign sts.count_zero = count_ff == '0;
   assign sts.scan_last  = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;
   assign sts.pipe_busy  = rd_vld_ff;
   assign rsp_data       = rsp_ff;

endmodule
